### rtl/core/dqs_pkg.sv
`default_nettype none

package dqs_pkg;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_DEL_FRONT = 3'd2,
    ACT_DEL_BACK  = 3'd3,
    ACT_READ_ALL  = 3'd4,
    ACT_SEARCH    = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

endpackage

`default_nettype wire

### rtl/core/dqs_ring.sv
`default_nettype none

module dqs_ring #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [dqs_pkg::VALUE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [dqs_pkg::VALUE_W-1:0] rd_data
);
  import dqs_pkg::*;

  // ring storage, contents undefined until written
  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/deque_with_search_core.sv
// insert or delete: the result goes through the emit state into the output register
// read all: each entry goes through issue and check; check waits on a stalled output
// search: issue and check for each entry walked from the front, then emit the result
// the walk is set by the single registered read port of the ring memory
// in_ready is high only while the sequencer sits in idle; one word at a time
// reset (rst, synchronous, active high) empties the deque and drops the output word
`default_nettype none

module deque_with_search_core #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dqs_pkg::ACTION_W-1:0]       action,
  input  logic signed [dqs_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dqs_pkg::STATUS_W-1:0]       status,
  output logic [dqs_pkg::POS_W-1:0]          position,
  output logic signed [dqs_pkg::VALUE_W-1:0] entry,
  output logic                               last
);
  import dqs_pkg::*;

  localparam int IW = $clog2(CAPACITY);     // ring slot index
  localparam int CW = $clog2(CAPACITY + 1); // entry count, holds CAPACITY itself
  localparam int SW = CW + 1;               // slot sum before wrap

  localparam logic [SW-1:0] CAP_S    = SW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
  localparam logic [IW-1:0] TOP_SLOT = IW'(CAPACITY - 1);

  // one-hot sequencer
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010, // read request for entry idx
    S_CHECK = 4'b0100, // read data back, compare or emit
    S_EMIT  = 4'b1000  // single result waiting for the output register
  } state_t;

  state_t             state, state_next;
  logic [IW-1:0]      front, front_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  action_t            act, act_next;
  logic [VALUE_W-1:0] key, key_next;
  status_t            pend_status, pend_status_next;
  logic [POS_W-1:0]   pend_pos, pend_pos_next;

  // output register
  logic               out_load;
  status_t            out_status_d;
  logic [POS_W-1:0]   out_pos_d;
  logic [VALUE_W-1:0] out_entry_d;
  logic               out_last_d;
  logic               out_free;

  // ring memory ports
  logic               wr_en, rd_en;
  logic [IW-1:0]      wr_addr, rd_addr;
  logic [VALUE_W-1:0] rd_data;

  // shared slot unit: front plus an offset up to CAPACITY, one wrap
  logic [CW-1:0]      slot_off;
  logic [SW-1:0]      slot_sum;
  logic [IW-1:0]      slot;

  logic [IW-1:0]      front_dec, front_inc;
  logic [CW-1:0]      idx_inc;
  logic               at_end;
  logic               accept;

  assign slot_off = (state == S_IDLE) ? count : idx;
  assign slot_sum = SW'(front) + SW'(slot_off);
  assign slot     = (slot_sum >= CAP_S) ? IW'(slot_sum - CAP_S) : IW'(slot_sum);

  assign front_dec = (front == '0) ? TOP_SLOT : front - IW'(1);
  assign front_inc = (front == TOP_SLOT) ? '0 : front + IW'(1);
  assign idx_inc   = idx + CW'(1);
  assign at_end    = (idx_inc == count);

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next       = state;
    front_next       = front;
    count_next       = count;
    idx_next         = idx;
    act_next         = act;
    key_next         = key;
    pend_status_next = pend_status;
    pend_pos_next    = pend_pos;
    wr_en            = 1'b0;
    wr_addr          = slot;
    rd_en            = 1'b0;
    rd_addr          = slot;
    out_load         = 1'b0;
    out_status_d     = pend_status;
    out_pos_d        = pend_pos;
    out_entry_d      = '0;
    out_last_d       = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          act_next         = action_t'(action);
          key_next         = value;
          idx_next         = '0;
          pend_status_next = ST_OK;
          pend_pos_next    = '0;
          case (action_t'(action))
            ACT_INS_FRONT: begin
              state_next = S_EMIT;
              if (count == CAP_C) begin
                pend_status_next = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = front_dec;
                front_next = front_dec;
                count_next = count + CW'(1);
              end
            end
            ACT_INS_BACK: begin
              state_next = S_EMIT;
              if (count == CAP_C) begin
                pend_status_next = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
              end
            end
            ACT_DEL_FRONT: begin
              state_next = S_EMIT;
              if (count == '0) begin
                pend_status_next = ST_EMPTY;
              end else begin
                front_next = front_inc;
                count_next = count - CW'(1);
              end
            end
            ACT_DEL_BACK: begin
              state_next = S_EMIT;
              if (count == '0) begin
                pend_status_next = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            ACT_READ_ALL: begin
              if (count == '0) begin
                pend_status_next = ST_EMPTY;
                state_next       = S_EMIT;
              end else begin
                state_next = S_ISSUE;
              end
            end
            ACT_SEARCH: begin
              if (count == '0) begin
                pend_status_next = ST_MISSING;
                state_next       = S_EMIT;
              end else begin
                state_next = S_ISSUE;
              end
            end
            default: begin
              // undefined action codes are dropped without a result
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_ISSUE: begin
        rd_en      = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (act == ACT_READ_ALL) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_status_d = ST_OK;
            out_pos_d    = POS_W'(idx);
            out_entry_d  = rd_data;
            out_last_d   = at_end;
            idx_next     = idx_inc;
            state_next   = at_end ? S_IDLE : S_ISSUE;
          end
        end else begin
          if (rd_data == key) begin
            pend_status_next = ST_OK;
            pend_pos_next    = POS_W'(idx);
            state_next       = S_EMIT;
          end else if (at_end) begin
            pend_status_next = ST_MISSING;
            pend_pos_next    = '0;
            state_next       = S_EMIT;
          end else begin
            idx_next   = idx_inc;
            state_next = S_ISSUE;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    act         <= act_next;
    key         <= key_next;
    pend_status <= pend_status_next;
    pend_pos    <= pend_pos_next;
  end

  // output word register, free again once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status   <= out_status_d;
      position <= out_pos_d;
      entry    <= out_entry_d;
      last     <= out_last_d;
    end
  end

  dqs_ring #(
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (key_next),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

### rtl/core/dqs_checker.sv
`default_nettype none

module dqs_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [dqs_pkg::ACTION_W-1:0]       action,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [dqs_pkg::STATUS_W-1:0]       status,
  input  logic [dqs_pkg::POS_W-1:0]          position,
  input  logic signed [dqs_pkg::VALUE_W-1:0] entry,
  input  logic                               last
);
  import dqs_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
      && $stable(entry) && $stable(last))
    else $error("output word changed while stalled");

  // a defined action drops in_ready in the cycle after it is accepted
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action <= ACT_SEARCH) |=> !in_ready)
    else $error("input ready right after a defined action");

  // only a read-all word can be a non-final word, and it is always ok
  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> status == ST_OK)
    else $error("non-final word without ok status");

  // error words carry no position, no entry and close the item
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (position == '0) && (entry == '0) && last)
    else $error("error word with payload");

endmodule

bind deque_with_search_core dqs_checker u_dqs_checker (.*);

`default_nettype wire
